FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the correlator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNC_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PNC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pnc_pkg.sv
// Shared constants and tables of the preamble normalised correlator.
`default_nettype none

package pnc_pkg;

    // Default width of the magnitude samples actually used.
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed payload widths of the channels.
    localparam int SAMPLE_W = 16;
    localparam int SCORE_W  = 16;

    // Window geometry.
    localparam int WIN_LEN = 32;
    localparam int WIN_AW  = $clog2(WIN_LEN);
    localparam int FILL_W  = $clog2(WIN_LEN + 1);

    // Preamble pulse positions inside the window, oldest sample at offset 0.
    localparam int TAP_COUNT = 8;
    localparam int TAP_OFS [TAP_COUNT] = '{0, 1, 3, 4, 14, 15, 18, 19};

    // 1.0 in unsigned Q1.15.
    localparam logic [SCORE_W-1:0] ONE_Q15 = 16'h8000;

endpackage

`default_nettype wire

FILE: hw/rtl/pnc_stream_if.sv
// Valid/ready stream interfaces for the sample and result channels.
`default_nettype none

interface pnc_sample_if;
    logic                          valid;
    logic                          ready;
    logic [pnc_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface pnc_result_if;
    logic                          valid;
    logic                          ready;
    logic [pnc_pkg::SCORE_W-1:0]   score;
    logic                          window_full;
    logic                          zero_energy;

    modport source (output valid, output score, output window_full, output zero_energy,
                    input ready);
    modport sink   (input valid, input score, input window_full, input zero_energy,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/preamble_normalized_correlator.sv
// Top level of the preamble normalised correlator with its sequencer and shared unit.
//
//  channel     modport  payload                              beat
//  sample_ch   sink     sample[15:0]                         one magnitude sample
//  result_ch   source   score[15:0] window_full zero_energy  one score per sample
//
// One sample goes from its beat to its result register via the squares of the leaving
// and the new sample, the energy update, SAMPLE_BITS + 4 square-root steps, a
// saturation guard and 16 quotient steps; root and quotient steps share one
// compare/subtract unit. A window of zero energy skips root and divide. No new sample
// is taken before the last one is done: sample_ch.ready is high only while the
// sequencer idles; a result that waits on result_ch holds the sequencer in its final
// state. Reset clears the window, the energy, the fill count and the handshake state.
`default_nettype none

module preamble_normalized_correlator #(
    parameter int SAMPLE_BITS = pnc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    pnc_sample_if.sink     sample_ch,
    pnc_result_if.source   result_ch
);

    // Derived widths.
    localparam int SB   = SAMPLE_BITS;
    localparam int PW   = SB + 3;        // sum of eight taps
    localparam int RW   = SB + 4;        // integer root of 8 * energy
    localparam int XW   = 2 * SB + 8;    // 8 * energy, width of the shared unit
    localparam int EW   = 2 * SB + 5;    // energy of 32 squares
    localparam int PRW  = 2 * SB;        // one square
    localparam int IW   = pnc_pkg::SAMPLE_W;
    localparam int EXW  = (SB > IW) ? SB : IW;
    localparam int DIV_STEPS = pnc_pkg::SCORE_W;
    localparam int STEP_MAX  = (RW > DIV_STEPS) ? RW : DIV_STEPS;
    localparam int CW   = $clog2(STEP_MAX + 1);
    localparam int WL   = pnc_pkg::WIN_LEN;
    localparam int FW   = pnc_pkg::FILL_W;

    // Sequencer codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQ_OLD = 3'd1;
    localparam logic [2:0] ST_SUB    = 3'd2;
    localparam logic [2:0] ST_ADD    = 3'd3;
    localparam logic [2:0] ST_ROOT   = 3'd4;
    localparam logic [2:0] ST_GUARD  = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // Control and state registers.
    logic [2:0]                   state_reg,  state_next;
    logic [SB-1:0]                win_reg  [WL];
    logic [SB-1:0]                win_next [WL];
    logic [EW-1:0]                energy_reg, energy_next;
    logic [FW-1:0]                fill_reg,   fill_next;
    logic                         out_valid_reg, out_valid_next;

    // Working registers.
    logic [SB-1:0]                new_reg,   new_next;
    logic [SB-1:0]                old_reg,   old_next;
    logic [PRW-1:0]               prod_reg,  prod_next;
    logic [PW-1:0]                ps_reg,    ps_next;
    logic [XW-1:0]                rem_reg,   rem_next;
    logic [XW-1:0]                root_reg,  root_next;
    logic [XW-1:0]                bit_reg,   bit_next;
    logic [CW-1:0]                cnt_reg,   cnt_next;
    logic [DIV_STEPS-1:0]         quot_reg,  quot_next;
    logic                         sat_reg,   sat_next;
    logic                         zero_reg,  zero_next;

    // Result register.
    logic [pnc_pkg::SCORE_W-1:0]  score_reg, score_next;
    logic                         full_reg,  full_next;
    logic                         zflag_reg, zflag_next;

    // Datapath nets.
    logic [EXW-1:0]               sample_ext;
    logic [SB-1:0]                sample_in;
    logic [SB-1:0]                mul_op;
    logic [PRW-1:0]               mul_res;
    logic [PW-1:0]                ps_sum;
    logic [EW-1:0]                energy_add;
    logic [XW-1:0]                alu_a;
    logic [XW-1:0]                alu_b;
    logic [XW:0]                  alu_diff;
    logic                         alu_ge;

    // Drop sample bits above the working width, widen when it exceeds the port.
    assign sample_ext = EXW'(sample_ch.sample);
    assign sample_in  = sample_ext[SB-1:0];

    // Single squarer: oldest sample first, then the newest one.
    assign mul_op  = (state_reg == ST_SQ_OLD) ? old_reg : new_reg;
    assign mul_res = mul_op * mul_op;

    // Preamble tap sum over the shifted window.
    always_comb
    begin
        ps_sum = '0;
        for (int k = 0; k < pnc_pkg::TAP_COUNT; k++)
        begin
            ps_sum = ps_sum + PW'(win_reg[pnc_pkg::WIN_AW'(pnc_pkg::TAP_OFS[k])]);
        end
    end

    assign energy_add = energy_reg + EW'(prod_reg);

    // Shared compare/subtract unit: root steps, saturation guard, quotient steps.
    always_comb
    begin
        case (state_reg)
            ST_ROOT:
            begin
                alu_a = rem_reg;
                alu_b = root_reg | bit_reg;
            end
            ST_GUARD:
            begin
                alu_a = XW'(ps_reg);
                alu_b = XW'({root_reg[RW-1:0], 1'b0});
            end
            ST_DIV:
            begin
                alu_a = (cnt_reg == '0) ? rem_reg : {rem_reg[XW-2:0], 1'b0};
                alu_b = XW'(root_reg[RW-1:0]);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = ~alu_diff[XW];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        win_next       = win_reg;
        energy_next    = energy_reg;
        fill_next      = fill_reg;
        new_next       = new_reg;
        old_next       = old_reg;
        prod_next      = prod_reg;
        ps_next        = ps_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        quot_next      = quot_reg;
        sat_next       = sat_reg;
        zero_next      = zero_reg;
        score_next     = score_reg;
        full_next      = full_reg;
        zflag_next     = zflag_reg;
        out_valid_next = out_valid_reg & ~result_ch.ready;

        case (state_reg)
            ST_IDLE:
            begin
                // Shift the window on a sample beat, capture the leaving sample.
                if (sample_ch.valid)
                begin
                    for (int k = 0; k < WL - 1; k++)
                    begin
                        win_next[k] = win_reg[k + 1];
                    end
                    win_next[WL-1] = sample_in;
                    new_next       = sample_in;
                    old_next       = win_reg[0];
                    if (fill_reg != FW'(WL))
                    begin
                        fill_next = fill_reg + FW'(1);
                    end
                    state_next = ST_SQ_OLD;
                end
            end
            ST_SQ_OLD:
            begin
                prod_next  = mul_res;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                // Remove the leaving square before adding the new one.
                energy_next = energy_reg - EW'(prod_reg);
                prod_next   = mul_res;
                ps_next     = ps_sum;
                state_next  = ST_ADD;
            end
            ST_ADD:
            begin
                energy_next = energy_add;
                zero_next   = (energy_add == '0);
                rem_next    = {energy_add, 3'b000};
                root_next   = '0;
                bit_next    = {2'b01, {(XW-2){1'b0}}};
                cnt_next    = '0;
                state_next  = (energy_add == '0) ? ST_DONE : ST_ROOT;
            end
            ST_ROOT:
            begin
                if (alu_ge)
                begin
                    rem_next  = alu_diff[XW-1:0];
                    root_next = {1'b0, root_reg[XW-1:1]} | bit_reg;
                end
                else
                begin
                    root_next = {1'b0, root_reg[XW-1:1]};
                end
                bit_next = {2'b00, bit_reg[XW-1:2]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(RW - 1))
                begin
                    state_next = ST_GUARD;
                end
            end
            ST_GUARD:
            begin
                // A tap sum of twice the root or more saturates outright.
                sat_next   = alu_ge;
                rem_next   = XW'(ps_reg);
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = alu_ge ? alu_diff[XW-1:0] : alu_a;
                quot_next = {quot_reg[DIV_STEPS-2:0], alu_ge};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the result register is free.
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    if (zero_reg)
                    begin
                        score_next = '0;
                    end
                    else if (sat_reg || (quot_reg > pnc_pkg::ONE_Q15))
                    begin
                        score_next = pnc_pkg::ONE_Q15;
                    end
                    else
                    begin
                        score_next = quot_reg;
                    end
                    full_next  = (fill_reg == FW'(WL));
                    zflag_next = zero_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
            fill_reg      <= '0;
            for (int k = 0; k < WL; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            energy_reg    <= energy_next;
            fill_reg      <= fill_next;
            win_reg       <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg   <= new_next;
        old_reg   <= old_next;
        prod_reg  <= prod_next;
        ps_reg    <= ps_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        bit_reg   <= bit_next;
        cnt_reg   <= cnt_next;
        quot_reg  <= quot_next;
        sat_reg   <= sat_next;
        zero_reg  <= zero_next;
        score_reg <= score_next;
        full_reg  <= full_next;
        zflag_reg <= zflag_next;
    end

    assign sample_ch.ready       = (state_reg == ST_IDLE);
    assign result_ch.valid       = out_valid_reg;
    assign result_ch.score       = score_reg;
    assign result_ch.window_full = full_reg;
    assign result_ch.zero_energy = zflag_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/pnc_checker.sv
// Port-level checker of the preamble normalised correlator and its bind.
`default_nettype none

`include "assert_macros.svh"

module pnc_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [pnc_pkg::SCORE_W-1:0]  score,
    input  wire logic                         zero_energy
);

    // Hold a stalled result beat.
    `PNC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(score), "stalled result beat changed")

    // Busy right after a sample beat.
    `PNC_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready, "sample port ready right after a beat")

    // No result appears in the cycle after a sample beat.
    `PNC_ASSERT_NEXT(a_no_early_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid), "result raised right after a sample beat")

    // Score never exceeds 1.0.
    `PNC_ASSERT_IMPLY(a_score_range, clk, rst_n, out_valid, score <= pnc_pkg::ONE_Q15, "score above 1.0")

    // Zero energy forces a zero score.
    `PNC_ASSERT_IMPLY(a_zero_score, clk, rst_n, out_valid && zero_energy, score == '0, "non-zero score with zero energy")

endmodule

bind preamble_normalized_correlator pnc_checker u_pnc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_ch.valid),
    .in_ready    (sample_ch.ready),
    .out_valid   (result_ch.valid),
    .out_ready   (result_ch.ready),
    .score       (result_ch.score),
    .zero_energy (result_ch.zero_energy)
);

`default_nettype wire
